### rtl/temperature_protection_trip_core_defines.svh
// Assertion macros for the temperature protection trip core.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef TEMPERATURE_PROTECTION_TRIP_CORE_DEFINES_SVH
`define TEMPERATURE_PROTECTION_TRIP_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tpt_pkg.sv
// Shared types and constants for the temperature protection trip core.
// No dependencies; every module refers to it by scoped names.
package tpt_pkg;

    localparam int TEMP_WIDTH = 16;
    localparam int LIMIT_W    = 16;
    localparam int CMP_W      = ((TEMP_WIDTH > LIMIT_W) ? TEMP_WIDTH : LIMIT_W) + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 8;
    localparam int PERIOD_W   = 16;
    localparam int COUNT_W    = 16;

    localparam int MS_PER_MINUTE = 60000;

    // Reset values of the registers and of the derived scale and tick count
    localparam int PERIOD_RST = 1000;
    localparam int DELAY_RST  = 5;
    localparam int OUTLET_LIMIT_RST = 90;
    localparam int RISE_LIMIT_RST   = 10;
    localparam int DIFF_LIMIT_RST   = 2;
    localparam int SCALE_RST  = MS_PER_MINUTE / PERIOD_RST;
    localparam int TICKS_RST  = DELAY_RST * MS_PER_MINUTE / PERIOD_RST;

    // Serial divider: dividend covers 255 * 60000
    localparam int DIVIDEND_W = 24;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTLET_EN    = 3'd0,
        CFG_DIFF_EN      = 3'd1,
        CFG_OUTLET_LIMIT = 3'd2,
        CFG_RISE_LIMIT   = 3'd3,
        CFG_DIFF_LIMIT   = 3'd4,
        CFG_DELAY_MIN    = 3'd5,
        CFG_PERIOD_MS    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        VERDICT_OK          = 3'd0,
        VERDICT_OVERTEMP    = 3'd1,
        VERDICT_FAST_RISE   = 3'd2,
        VERDICT_MIN_DIFF    = 3'd3,
        VERDICT_SENSOR_FAIL = 3'd4
    } t_verdict;

    typedef struct packed {
        logic signed [TEMP_WIDTH-1:0] outlet_temp;
        logic signed [TEMP_WIDTH-1:0] inlet_temp;
        logic signed [TEMP_WIDTH-1:0] prev_outlet_temp;
        logic                         outlet_sensor_ok;
        logic                         inlet_sensor_ok;
        logic                         clear_delay;
    } t_in;

    typedef struct packed {
        t_verdict verdict;
        logic     tripped;
    } t_out;

    // Configuration as seen by the evaluation logic, derived values included
    typedef struct packed {
        logic                      outlet_en;
        logic                      diff_en;
        logic signed [LIMIT_W-1:0] outlet_limit;
        logic signed [LIMIT_W-1:0] rise_limit;
        logic signed [LIMIT_W-1:0] diff_limit;
        logic [PERIOD_W-1:0]       scale;
        logic [COUNT_W-1:0]        ticks;
    } t_cfg;

endpackage

### rtl/temperature_protection_trip_core.sv
// Top level of the temperature protection trip core.
// Depends on tpt_pkg, tpt_cfg (with tpt_div) and tpt_eval.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-----------------------
//  in      | i_in_valid / o_in_ready / i_in_data        | one protection tick
//  out     | o_out_valid / i_out_ready / o_out_data     | one verdict per tick
//  cfg     | i_cfg_we / i_cfg_idx / i_cfg_wdata         | one register write
//
// Rate: one beat per cycle while no divider pass runs and verdicts are taken; a
//   verdict is offered once its tick has passed the input register and then the
//   result register.
// A write to period_ms or diff_delay_minutes drops o_in_ready while the serial
//   divider forms the scale and delay tick count, one quotient bit per cycle
//   over a 24-bit dividend.
// Reset: synchronous, active low; derived scale (60) and delay ticks (300)
//   come straight out of reset, so no divider pass follows it.
// Stalls: a held verdict keeps the result register; the input register still
//   refills behind it, then o_in_ready drops until the verdict is taken.
module temperature_protection_trip_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tpt_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tpt_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tpt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    tpt_pkg::t_cfg                 cfg;
    logic                          cfg_busy;

    logic                          r_in_valid;
    tpt_pkg::t_in                  r_in;
    logic                          r_out_valid;
    tpt_pkg::t_out                 r_out;
    logic [tpt_pkg::COUNT_W-1:0]   r_delay_count;

    tpt_pkg::t_out                 res;
    logic [tpt_pkg::COUNT_W-1:0]   n_delay_count;
    logic                          in_fire;
    logic                          advance;

    tpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_busy      (cfg_busy)
    );

    tpt_eval u_eval (
        .i_item  (r_in),
        .i_cfg   (cfg),
        .i_count (r_delay_count),
        .o_res   (res),
        .o_count (n_delay_count)
    );

    // Advance the held tick into the result register when that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    // Take a new tick when the input register empties this cycle; hold off
    // while the derived values are being recomputed
    assign o_in_ready = !cfg_busy && (!r_in_valid || advance);
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_delay_count <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                // the delay counter moves only as a tick is evaluated
                r_delay_count <= n_delay_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture on the beat, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/tpt_div.sv
// Serial restoring divider deriving scale and start-delay tick count.
// Depends on tpt_pkg; one quotient bit per cycle for both dividends.
module tpt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tpt_pkg::PERIOD_W-1:0]  i_period,
    input  logic [tpt_pkg::DELAY_W-1:0]   i_delay_min,
    output logic                          o_busy,
    output logic [tpt_pkg::PERIOD_W-1:0]  o_scale,
    output logic [tpt_pkg::COUNT_W-1:0]   o_ticks
);

    localparam int DW = tpt_pkg::DIVIDEND_W;
    localparam int RW = tpt_pkg::PERIOD_W;

    logic                          r_run;
    logic [tpt_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [RW-1:0]                 r_div;
    logic [DW-1:0]                 r_num_a, r_num_b;
    logic [RW-1:0]                 r_rem_a, r_rem_b;
    logic [RW-1:0]                 r_scale;
    logic [tpt_pkg::COUNT_W-1:0]   r_ticks;

    logic [DW-1:0] n_num_a, n_num_b;
    logic [RW-1:0] n_rem_a, n_rem_b;
    logic [DW-1:0] dm_ext;
    logic          last;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [DW+RW-1:0] div_step(
        input logic [DW-1:0] num,
        input logic [RW-1:0] rem,
        input logic [RW-1:0] dvs
    );
        logic [RW:0] rem2;
        logic        ge;
        logic [RW:0] diff;
        rem2 = {rem, num[DW-1]};
        ge   = (rem2 >= {1'b0, dvs});
        diff = rem2 - {1'b0, dvs};
        return {num[DW-2:0], ge, (ge ? diff[RW-1:0] : rem2[RW-1:0])};
    endfunction

    assign {n_num_a, n_rem_a} = div_step(r_num_a, r_rem_a, r_div);
    assign {n_num_b, n_rem_b} = div_step(r_num_b, r_rem_b, r_div);
    assign dm_ext = DW'(i_delay_min);
    assign last   = (r_cnt == tpt_pkg::DIV_CNT_W'(tpt_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_cnt   <= '0;
            r_scale <= RW'(tpt_pkg::SCALE_RST);
            r_ticks <= tpt_pkg::COUNT_W'(tpt_pkg::TICKS_RST);
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_run   <= 1'b0;
                r_scale <= n_num_a[RW-1:0];
                // saturate the delay tick count at the counter's full scale
                r_ticks <= (|n_num_b[DW-1:tpt_pkg::COUNT_W]) ? '1
                                                             : n_num_b[tpt_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div   <= (i_period == '0) ? RW'(1) : i_period;
            r_num_a <= DW'(tpt_pkg::MS_PER_MINUTE);
            r_num_b <= dm_ext * DW'(tpt_pkg::MS_PER_MINUTE);
            r_rem_a <= '0;
            r_rem_b <= '0;
        end else if (r_run) begin
            r_num_a <= n_num_a;
            r_num_b <= n_num_b;
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
        end
    end

    assign o_busy  = r_run;
    assign o_scale = r_scale;
    assign o_ticks = r_ticks;

endmodule

### rtl/tpt_cfg.sv
// Configuration registers and derivation of scale and delay ticks.
// Depends on tpt_pkg and tpt_div.
module tpt_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tpt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output tpt_pkg::t_cfg                   o_cfg,
    output logic                            o_busy
);

    logic                               r_outlet_en;
    logic                               r_diff_en;
    logic signed [tpt_pkg::LIMIT_W-1:0] r_outlet_limit;
    logic signed [tpt_pkg::LIMIT_W-1:0] r_rise_limit;
    logic signed [tpt_pkg::LIMIT_W-1:0] r_diff_limit;
    logic [tpt_pkg::DELAY_W-1:0]        r_delay_min;
    logic [tpt_pkg::PERIOD_W-1:0]       r_period;
    logic                               r_kick;
    logic                               n_kick;
    logic                               div_busy;
    logic [tpt_pkg::PERIOD_W-1:0]       scale;
    logic [tpt_pkg::COUNT_W-1:0]        ticks;
    tpt_pkg::t_cfg_idx                  idx;

    assign idx = tpt_pkg::t_cfg_idx'(i_cfg_idx);

    always_comb begin
        n_kick = 1'b0;
        if (i_cfg_we) begin
            unique case (idx)
                tpt_pkg::CFG_DELAY_MIN,
                tpt_pkg::CFG_PERIOD_MS: n_kick = 1'b1;
                default:                n_kick = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outlet_en    <= 1'b0;
            r_diff_en      <= 1'b0;
            r_outlet_limit <= tpt_pkg::LIMIT_W'(tpt_pkg::OUTLET_LIMIT_RST);
            r_rise_limit   <= tpt_pkg::LIMIT_W'(tpt_pkg::RISE_LIMIT_RST);
            r_diff_limit   <= tpt_pkg::LIMIT_W'(tpt_pkg::DIFF_LIMIT_RST);
            r_delay_min    <= tpt_pkg::DELAY_W'(tpt_pkg::DELAY_RST);
            r_period       <= tpt_pkg::PERIOD_W'(tpt_pkg::PERIOD_RST);
            r_kick         <= 1'b0;
        end else begin
            r_kick <= n_kick;
            if (i_cfg_we) begin
                unique case (idx)
                    tpt_pkg::CFG_OUTLET_EN:    r_outlet_en    <= i_cfg_wdata[0];
                    tpt_pkg::CFG_DIFF_EN:      r_diff_en      <= i_cfg_wdata[0];
                    tpt_pkg::CFG_OUTLET_LIMIT: r_outlet_limit <= i_cfg_wdata;
                    tpt_pkg::CFG_RISE_LIMIT:   r_rise_limit   <= i_cfg_wdata;
                    tpt_pkg::CFG_DIFF_LIMIT:   r_diff_limit   <= i_cfg_wdata;
                    tpt_pkg::CFG_DELAY_MIN:    r_delay_min    <= i_cfg_wdata[tpt_pkg::DELAY_W-1:0];
                    tpt_pkg::CFG_PERIOD_MS:    r_period       <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    tpt_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_kick),
        .i_period    (r_period),
        .i_delay_min (r_delay_min),
        .o_busy      (div_busy),
        .o_scale     (scale),
        .o_ticks     (ticks)
    );

    assign o_busy = r_kick | div_busy;

    assign o_cfg.outlet_en    = r_outlet_en;
    assign o_cfg.diff_en      = r_diff_en;
    assign o_cfg.outlet_limit = r_outlet_limit;
    assign o_cfg.rise_limit   = r_rise_limit;
    assign o_cfg.diff_limit   = r_diff_limit;
    assign o_cfg.scale        = scale;
    assign o_cfg.ticks        = ticks;

endmodule

### rtl/tpt_eval.sv
// Verdict logic for one tick and next value of the start-delay counter.
// Depends on tpt_pkg; purely combinational.
module tpt_eval (
    input  tpt_pkg::t_in                  i_item,
    input  tpt_pkg::t_cfg                 i_cfg,
    input  logic [tpt_pkg::COUNT_W-1:0]   i_count,
    output tpt_pkg::t_out                 o_res,
    output logic [tpt_pkg::COUNT_W-1:0]   o_count
);

    localparam int W  = tpt_pkg::TEMP_WIDTH;
    localparam int CW = tpt_pkg::CMP_W;
    localparam int PW = W + tpt_pkg::PERIOD_W;

    logic signed [CW-1:0] outlet_x, limit_x;
    logic [W:0]           rise_s, diff_s;
    logic                 rise_pos, diff_pos;
    logic [PW-1:0]        prod_full;
    logic [W-1:0]         prod_sat;
    logic                 over_trip, rise_trip, diff_trip;
    logic [tpt_pkg::COUNT_W-1:0] base;
    tpt_pkg::t_verdict    verdict;

    assign outlet_x = CW'($signed(i_item.outlet_temp));
    assign limit_x  = CW'($signed(i_cfg.outlet_limit));
    assign over_trip = (outlet_x >= limit_x);

    assign rise_s = {i_item.outlet_temp[W-1], i_item.outlet_temp}
                  - {i_item.prev_outlet_temp[W-1], i_item.prev_outlet_temp};
    assign diff_s = {i_item.outlet_temp[W-1], i_item.outlet_temp}
                  - {i_item.inlet_temp[W-1], i_item.inlet_temp};
    assign rise_pos = !rise_s[W] && (rise_s != '0);
    assign diff_pos = !diff_s[W] && (diff_s != '0);

    // per-minute rise, saturated to the temperature width
    assign prod_full = PW'(rise_s[W-1:0]) * PW'(i_cfg.scale);
    assign prod_sat  = (|prod_full[PW-1:W]) ? '1 : prod_full[W-1:0];

    // magnitudes are unsigned: a negative rise limit trips on any positive rise,
    // a negative difference limit never does
    assign rise_trip = rise_pos && (i_cfg.rise_limit[tpt_pkg::LIMIT_W-1]
                     || (CW'(prod_sat) >= CW'($unsigned(i_cfg.rise_limit))));
    assign diff_trip = diff_pos && !i_cfg.diff_limit[tpt_pkg::LIMIT_W-1]
                     && (CW'(diff_s[W-1:0]) <= CW'($unsigned(i_cfg.diff_limit)));

    assign base = i_item.clear_delay ? '0 : i_count;

    always_comb begin
        verdict = tpt_pkg::VERDICT_OK;
        o_count = base;
        if (i_cfg.outlet_en && !i_item.outlet_sensor_ok) begin
            verdict = tpt_pkg::VERDICT_SENSOR_FAIL;
        end else if (i_cfg.outlet_en && over_trip) begin
            verdict = tpt_pkg::VERDICT_OVERTEMP;
        end else if (i_cfg.outlet_en && rise_trip) begin
            verdict = tpt_pkg::VERDICT_FAST_RISE;
        end else if (i_cfg.diff_en) begin
            if (!i_item.outlet_sensor_ok || !i_item.inlet_sensor_ok) begin
                verdict = tpt_pkg::VERDICT_SENSOR_FAIL;
            end else if (base >= i_cfg.ticks) begin
                if (diff_trip) begin
                    verdict = tpt_pkg::VERDICT_MIN_DIFF;
                end
            end else begin
                o_count = base + 1'b1;
            end
        end
    end

    assign o_res.verdict = verdict;
    assign o_res.tripped = (verdict != tpt_pkg::VERDICT_OK);

endmodule

### rtl/tpt_checker.sv
// Port-level checker for the temperature protection trip core, with bind.
// Depends on tpt_pkg and the assertion macros header.
`include "temperature_protection_trip_core_defines.svh"

module tpt_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  tpt_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx
);

    // a stalled verdict stays put
    `TPT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "verdict changed while stalled")

    // trip flag agrees with the verdict code
    `TPT_ASSERT_NOW(a_trip_flag, o_out_valid, o_out_data.tripped == (o_out_data.verdict != tpt_pkg::VERDICT_OK), "tripped disagrees with verdict")

    // a period write drops o_in_ready while the scale is recomputed
    `TPT_ASSERT_NEXT(a_period_hold, i_cfg_we && (i_cfg_idx == tpt_pkg::CFG_PERIOD_MS), !o_in_ready, "tick taken during period derivation")

    // a delay write drops o_in_ready while the tick count is recomputed
    `TPT_ASSERT_NEXT(a_delay_hold, i_cfg_we && (i_cfg_idx == tpt_pkg::CFG_DELAY_MIN), !o_in_ready, "tick taken during delay derivation")

endmodule

bind temperature_protection_trip_core tpt_checker u_tpt_checker (.*);
